/* src/quadrature_encoder_accel_scanner_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the encoder scanner checker
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_ACCEL_SCANNER_ASSERT_SVH
`define QUADRATURE_ENCODER_ACCEL_SCANNER_ASSERT_SVH

// same-cycle implication
`define QEAS_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("qeas check failed");

// next-cycle implication
`define QEAS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("qeas check failed");

`endif

/* src/qeas_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qeas_pkg
// Shared constants and types of the quadrature encoder scanner.
// ---------------------------------------------------------------------------
package qeas_pkg;

  localparam int ENCODER_COUNT = 4;
  localparam int BUTTON_COUNT  = 7;
  localparam int EVENT_COUNT   = ENCODER_COUNT + BUTTON_COUNT;

  localparam int SCAN_W      = 16;
  localparam int SRC_W       = 3;
  localparam int AMOUNT_W    = 5;
  localparam int SPEED_W     = 4;
  localparam int TICKS_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ENC_MAP_W   = 8 * ENCODER_COUNT;
  localparam int BTN_MAP_W   = 4 * BUTTON_COUNT;

  localparam logic [31:0] ENC_MAP_RESET_FULL = 32'h1032AB89;
  localparam logic [31:0] BTN_MAP_RESET_FULL = 32'h0657FEDC;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd60;
  localparam logic [SPEED_W-1:0] STEP_RESET  = 4'd3;
  localparam logic [SPEED_W-1:0] MAX_RESET   = 4'd10;

  localparam logic [3:0] HIST_UP   = 4'd14;
  localparam logic [3:0] HIST_DOWN = 4'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENCODER_PIN_MAP = 3'd0,
    REG_BUTTON_PIN_MAP  = 3'd1,
    REG_LOCKOUT_TICKS   = 3'd2,
    REG_SPEED_STEP      = 3'd3,
    REG_SPEED_MAX       = 3'd4
  } reg_index_t;

  typedef logic signed [AMOUNT_W-1:0] amount_t;

  typedef struct packed {
    logic [ENC_MAP_W-1:0] encoder_pin_map;
    logic [BTN_MAP_W-1:0] button_pin_map;
    logic [TICKS_W-1:0]   lockout_ticks;
    logic [SPEED_W-1:0]   speed_step;
    logic [SPEED_W-1:0]   speed_max;
  } cfg_t;

  typedef struct packed {
    logic [EVENT_COUNT-1:0]             mask;
    amount_t [ENCODER_COUNT-1:0]        amount;
  } event_set_t;

endpackage

/* src/qeas_cfg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qeas_cfg
// Configuration register file, written by index.
// ---------------------------------------------------------------------------
module qeas_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_en,
  input  logic [qeas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qeas_pkg::CFG_DATA_W-1:0]  cfg_data,
  output qeas_pkg::cfg_t                 cfg
);
  import qeas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.encoder_pin_map <= ENC_MAP_RESET_FULL[ENC_MAP_W-1:0];
      cfg.button_pin_map  <= BTN_MAP_RESET_FULL[BTN_MAP_W-1:0];
      cfg.lockout_ticks   <= TICKS_RESET;
      cfg.speed_step      <= STEP_RESET;
      cfg.speed_max       <= MAX_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_ENCODER_PIN_MAP: cfg.encoder_pin_map <= cfg_data[ENC_MAP_W-1:0];
        REG_BUTTON_PIN_MAP:  cfg.button_pin_map  <= cfg_data[BTN_MAP_W-1:0];
        REG_LOCKOUT_TICKS:   cfg.lockout_ticks   <= cfg_data[TICKS_W-1:0];
        REG_SPEED_STEP:      cfg.speed_step      <= cfg_data[SPEED_W-1:0];
        REG_SPEED_MAX:       cfg.speed_max       <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/qeas_track.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qeas_track
// Encoder and button state; turns one scan word into a set of events.
// ---------------------------------------------------------------------------
module qeas_track (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [qeas_pkg::SCAN_W-1:0] scan_word,
  input  qeas_pkg::cfg_t              cfg,
  output qeas_pkg::event_set_t        events
);
  import qeas_pkg::*;

  logic [3:0]         phase_history    [ENCODER_COUNT];
  logic [1:0]         locked_direction [ENCODER_COUNT];
  logic [TICKS_W-1:0] lockout_count    [ENCODER_COUNT];
  logic [SPEED_W-1:0] turn_speed       [ENCODER_COUNT];
  logic [BUTTON_COUNT-1:0] button_previous;
  logic [1:0]         scan_phase;

  logic [3:0]         phase_history_next    [ENCODER_COUNT];
  logic [1:0]         locked_direction_next [ENCODER_COUNT];
  logic [TICKS_W-1:0] lockout_count_next    [ENCODER_COUNT];
  logic [SPEED_W-1:0] turn_speed_next       [ENCODER_COUNT];
  logic [BUTTON_COUNT-1:0] button_pressed;

  always_comb begin
    logic                phase_a;
    logic                phase_b;
    logic [3:0]          hist;
    logic                step_up;
    logic                step_down;
    logic [SPEED_W:0]    sp;
    events = '0;
    for (int k = 0; k < ENCODER_COUNT; k++) begin
      phase_a = ~scan_word[cfg.encoder_pin_map[8*k +: 4]];
      phase_b = ~scan_word[cfg.encoder_pin_map[8*k+4 +: 4]];
      hist = {phase_history[k][1:0], phase_b, phase_a};
      step_up   = (hist == HIST_UP)   && (locked_direction[k] != DIR_DOWN);
      step_down = (hist == HIST_DOWN) && (locked_direction[k] != DIR_UP);
      phase_history_next[k]    = hist;
      locked_direction_next[k] = locked_direction[k];
      lockout_count_next[k]    = lockout_count[k];
      sp = {1'b0, turn_speed[k]};
      if (step_up || step_down) begin
        events.mask[k]   = 1'b1;
        events.amount[k] = step_up ? amount_t'({1'b0, turn_speed[k]})
                                   : amount_t'(5'd0 - {1'b0, turn_speed[k]});
        sp = {1'b0, turn_speed[k]} + {1'b0, cfg.speed_step};
        locked_direction_next[k] = step_up ? DIR_UP : DIR_DOWN;
        lockout_count_next[k]    = cfg.lockout_ticks;
      end else begin
        if (lockout_count[k] > TICKS_W'(1)) begin
          lockout_count_next[k] = lockout_count[k] - TICKS_W'(1);
        end else begin
          lockout_count_next[k]    = '0;
          locked_direction_next[k] = DIR_NONE;
        end
        if ((turn_speed[k] > SPEED_W'(1)) && (scan_phase == 2'd0)) begin
          sp = {1'b0, turn_speed[k]} - (SPEED_W+1)'(1);
        end
      end
      turn_speed_next[k] = (sp > {1'b0, cfg.speed_max}) ? cfg.speed_max
                                                        : sp[SPEED_W-1:0];
    end
    for (int j = 0; j < BUTTON_COUNT; j++) begin
      button_pressed[j] = ~scan_word[cfg.button_pin_map[4*j +: 4]];
      events.mask[ENCODER_COUNT + j] = ~button_previous[j] & button_pressed[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENCODER_COUNT; k++) begin
        phase_history[k]    <= '0;
        locked_direction[k] <= DIR_NONE;
        lockout_count[k]    <= '0;
        turn_speed[k]       <= SPEED_W'(1);
      end
      button_previous <= '1;
      scan_phase      <= '0;
    end else if (accept) begin
      for (int k = 0; k < ENCODER_COUNT; k++) begin
        phase_history[k]    <= phase_history_next[k];
        locked_direction[k] <= locked_direction_next[k];
        lockout_count[k]    <= lockout_count_next[k];
        turn_speed[k]       <= turn_speed_next[k];
      end
      button_previous <= button_pressed;
      scan_phase      <= scan_phase + 2'd1;
    end
  end

endmodule

/* src/qeas_emit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qeas_emit
// Pending event set and output register; sends one event word per cycle while event_stall is low.
// ---------------------------------------------------------------------------
module qeas_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  qeas_pkg::event_set_t          events,
  output logic                          ready,
  output logic                          event_valid,
  input  logic                          event_stall,
  output logic                          event_kind,
  output logic [qeas_pkg::SRC_W-1:0]    source_index,
  output logic signed [qeas_pkg::AMOUNT_W-1:0] turn_amount,
  output logic                          last_event
);
  import qeas_pkg::*;

  logic [EVENT_COUNT-1:0]      pending;
  amount_t [ENCODER_COUNT-1:0] amount;
  logic [EVENT_COUNT-1:0]      pick;
  logic [EVENT_COUNT-1:0]      rest;
  logic                        advance;
  logic                        pick_kind;
  logic [SRC_W-1:0]            pick_src;
  amount_t                     pick_amount;

  assign advance = ~event_valid | ~event_stall;
  assign pick    = pending & (~pending + EVENT_COUNT'(1));
  assign rest    = pending & ~pick;
  assign ready   = (pending == '0) || (advance && (rest == '0));

  always_comb begin
    pick_kind   = 1'b0;
    pick_src    = '0;
    pick_amount = '0;
    for (int i = 0; i < ENCODER_COUNT; i++) begin
      if (pick[i]) begin
        pick_src    = SRC_W'(i);
        pick_amount = amount[i];
      end
    end
    for (int j = 0; j < BUTTON_COUNT; j++) begin
      if (pick[ENCODER_COUNT + j]) begin
        pick_kind = 1'b1;
        pick_src  = SRC_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      event_valid <= 1'b0;
    end else begin
      if (accept) begin
        pending <= events.mask;
      end else if (advance) begin
        pending <= rest;
      end
      if (advance) begin
        event_valid <= (pending != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amount <= events.amount;
    end
    if (advance) begin
      event_kind   <= pick_kind;
      source_index <= pick_src;
      turn_amount  <= pick_amount;
      last_event   <= (rest == '0);
    end
  end

endmodule

/* src/quadrature_encoder_accel_scanner.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_encoder_accel_scanner
// Quadrature encoder and button scanner with turn acceleration.
// ---------------------------------------------------------------------------
//   channel  signals                                   direction
//   scan     scan_valid, scan_stall, scan_word         in
//   event    event_valid, event_stall, event_kind,
//            source_index, turn_amount, last_event     out
//   config   cfg_en, cfg_index, cfg_data               in
//
// A scan is decoded and its events registered into the pending set in the
// cycle it is accepted; they leave through the output register one event
// word per cycle while event_stall is low. The next scan is accepted as
// the last pending event moves out; scans with zero or one event are taken
// every cycle while event_stall is low. rst is synchronous and clears all
// encoder, button and queue state. A stalled word holds; pending ones wait.
// ---------------------------------------------------------------------------
module quadrature_encoder_accel_scanner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              scan_valid,
  output logic                              scan_stall,
  input  logic [qeas_pkg::SCAN_W-1:0]       scan_word,
  output logic                              event_valid,
  input  logic                              event_stall,
  output logic                              event_kind,
  output logic [qeas_pkg::SRC_W-1:0]        source_index,
  output logic signed [qeas_pkg::AMOUNT_W-1:0] turn_amount,
  output logic                              last_event,
  input  logic                              cfg_en,
  input  logic [qeas_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [qeas_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qeas_pkg::*;

  cfg_t       cfg;
  event_set_t events;
  logic       ready;
  logic       accept;

  assign scan_stall = ~ready;
  assign accept     = scan_valid & ready;

  qeas_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qeas_track u_track (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .scan_word (scan_word),
    .cfg       (cfg),
    .events    (events)
  );

  qeas_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .events       (events),
    .ready        (ready),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .source_index (source_index),
    .turn_amount  (turn_amount),
    .last_event   (last_event)
  );

endmodule

/* src/qeas_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qeas_checker
// Port-level checks of the encoder scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "quadrature_encoder_accel_scanner_assert.svh"

module qeas_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              event_valid,
  input  logic                              event_stall,
  input  logic                              event_kind,
  input  logic [qeas_pkg::SRC_W-1:0]        source_index,
  input  logic signed [qeas_pkg::AMOUNT_W-1:0] turn_amount,
  input  logic                              last_event
);

  `QEAS_ASSERT_NEXT(a_event_hold, clk, rst, event_valid && event_stall,
    event_valid && $stable(event_kind) && $stable(source_index) &&
    $stable(turn_amount) && $stable(last_event))

  `QEAS_ASSERT_NOW(a_button_no_amount, clk, rst, event_valid && event_kind, turn_amount == 5'sd0)

  `QEAS_ASSERT_NOW(a_source_range, clk, rst, event_valid, source_index != 3'd7)

  `QEAS_ASSERT_NOW(a_quiet_after_reset, clk, rst, $past(rst), !event_valid)

endmodule

bind quadrature_encoder_accel_scanner qeas_checker u_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the encoder and button scanner against a cycle-free prediction of
// its events. Quadrature walks with random content, noise and skipped
// phases are sent under several register settings, with random idling on
// both channels and one long hold-off on the event side.
// ---------------------------------------------------------------------------
module testbench;
  import qeas_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int DRAIN      = 16;
  localparam int IDLE_LIMIT = 2000;

  localparam logic KIND_TURN  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  // quadrature pair codes (bit 0 phase A low, bit 1 phase B low) in walk order
  localparam logic [7:0] GRAY_SEQ = {2'd2, 2'd3, 2'd1, 2'd0};

  typedef struct packed {
    logic               kind;
    logic [SRC_W-1:0]   src;
    amount_t            amount;
    logic               last;
  } scan_event_t;

  class scan_event_model;
    logic [ENC_MAP_W-1:0] enc_map;
    logic [BTN_MAP_W-1:0] btn_map;
    logic [TICKS_W-1:0]   ticks;
    logic [SPEED_W-1:0]   speed_step;
    logic [SPEED_W-1:0]   speed_max;
    logic [3:0]           history [ENCODER_COUNT];
    logic [1:0]           lock_dir [ENCODER_COUNT];
    logic [TICKS_W-1:0]   lock_cnt [ENCODER_COUNT];
    logic [SPEED_W-1:0]   speed [ENCODER_COUNT];
    logic                 btn_prev [BUTTON_COUNT];
    logic [1:0]           scan_phase;
    scan_event_t          expected_events [$];
    int                   errors;

    function new();
      enc_map    = ENC_MAP_RESET_FULL[ENC_MAP_W-1:0];
      btn_map    = BTN_MAP_RESET_FULL[BTN_MAP_W-1:0];
      ticks      = TICKS_RESET;
      speed_step = STEP_RESET;
      speed_max  = MAX_RESET;
      for (int k = 0; k < ENCODER_COUNT; k++) begin
        history[k]  = 4'd0;
        lock_dir[k] = DIR_NONE;
        lock_cnt[k] = '0;
        speed[k]    = 4'd1;
      end
      for (int k = 0; k < BUTTON_COUNT; k++) btn_prev[k] = 1'b1;
      scan_phase = 2'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENCODER_PIN_MAP: enc_map = data[ENC_MAP_W-1:0];
        REG_BUTTON_PIN_MAP:  btn_map = data[BTN_MAP_W-1:0];
        REG_LOCKOUT_TICKS:   ticks = data[TICKS_W-1:0];
        REG_SPEED_STEP:      speed_step = data[SPEED_W-1:0];
        REG_SPEED_MAX:       speed_max = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void note_scan(logic [SCAN_W-1:0] w);
      scan_event_t found [$];
      scan_event_t ev;
      logic [3:0]  h;
      logic        is_low;
      int          sp;
      int          amt;
      for (int k = 0; k < ENCODER_COUNT; k++) begin
        h = {history[k][1:0], ~w[enc_map[8*k+4 +: 4]], ~w[enc_map[8*k +: 4]]};
        history[k] = h;
        sp = int'(speed[k]);
        if ((h == HIST_UP && lock_dir[k] != DIR_DOWN) ||
            (h == HIST_DOWN && lock_dir[k] != DIR_UP)) begin
          amt = (h == HIST_UP) ? sp : -sp;
          ev.kind   = KIND_TURN;
          ev.src    = k[SRC_W-1:0];
          ev.amount = amt[AMOUNT_W-1:0];
          ev.last   = 1'b0;
          found.push_back(ev);
          sp = sp + int'(speed_step);
          lock_dir[k] = (h == HIST_UP) ? DIR_UP : DIR_DOWN;
          lock_cnt[k] = ticks;
        end else begin
          if (lock_cnt[k] > TICKS_W'(1)) begin
            lock_cnt[k] = lock_cnt[k] - TICKS_W'(1);
          end else begin
            lock_cnt[k] = '0;
            lock_dir[k] = DIR_NONE;
          end
          if (sp > 1 && scan_phase == 2'd0) sp = sp - 1;
        end
        if (sp > int'(speed_max)) sp = int'(speed_max);
        speed[k] = sp[SPEED_W-1:0];
      end
      for (int k = 0; k < BUTTON_COUNT; k++) begin
        is_low = ~w[btn_map[4*k +: 4]];
        if (!btn_prev[k] && is_low) begin
          ev.kind   = KIND_PRESS;
          ev.src    = k[SRC_W-1:0];
          ev.amount = '0;
          ev.last   = 1'b0;
          found.push_back(ev);
        end
        btn_prev[k] = is_low;
      end
      scan_phase = scan_phase + 2'd1;
      if (found.size() > 0) begin
        ev = found.pop_back();
        ev.last = 1'b1;
        found.push_back(ev);
      end
      foreach (found[i]) expected_events.push_back(found[i]);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_event(scan_event_t got);
      scan_event_t want;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual kind %0d source %0d amount %0d",
                 $time, got.kind, got.src, $signed(got.amount));
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", 32'(want.kind), 32'(got.kind));
      compare_field("source_index", 32'(want.src), 32'(got.src));
      compare_field("turn_amount", 32'($signed(want.amount)), 32'($signed(got.amount)));
      compare_field("last_event", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    scan_valid;
  logic                    scan_stall;
  logic [SCAN_W-1:0]       scan_word;
  logic                    event_valid;
  logic                    event_stall;
  logic                    event_kind;
  logic [SRC_W-1:0]        source_index;
  logic signed [AMOUNT_W-1:0] turn_amount;
  logic                    last_event;
  logic                    cfg_en;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  scan_event_model scan_model;
  scan_event_t     seen;
  int              gray_pos [ENCODER_COUNT];
  int              spin_dir [ENCODER_COUNT];
  bit              quiet;
  bit              hold_req;
  int              idle_cycles;

  quadrature_encoder_accel_scanner uut (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .scan_word    (scan_word),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .source_index (source_index),
    .turn_amount  (turn_amount),
    .last_event   (last_event),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // events of an earlier scan are checked before the scan taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (event_valid && !event_stall) begin
        seen.kind   = event_kind;
        seen.src    = source_index;
        seen.amount = turn_amount;
        seen.last   = last_event;
        scan_model.check_event(seen);
      end
      if (scan_valid && !scan_stall) scan_model.note_scan(scan_word);
    end
  end

  always @(posedge clk) begin
    if (rst || (scan_valid && !scan_stall) || (event_valid && !event_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    event_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        event_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        event_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        event_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        event_stall <= 1'b0;
      end
    end
  end

  task automatic send_scan(input logic [SCAN_W-1:0] w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      scan_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    scan_valid <= 1'b1;
    scan_word <= w;
    @(posedge clk);
    while (scan_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    scan_model.set_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [31:0] enc, input logic [31:0] btn,
                                input logic [7:0] ticks, input logic [3:0] stp,
                                input logic [3:0] mx);
    write_reg(REG_UNMAPPED, $urandom);
    write_reg(REG_ENCODER_PIN_MAP, enc);
    write_reg(REG_BUTTON_PIN_MAP, btn);
    write_reg(REG_LOCKOUT_TICKS, {24'd0, ticks});
    write_reg(REG_SPEED_STEP, {28'd0, stp});
    write_reg(REG_SPEED_MAX, {28'd0, mx});
    cfg_en <= 1'b0;
  endtask

  task automatic settle();
    scan_valid <= 1'b0;
    @(posedge clk);
    while (scan_model.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [SCAN_W-1:0] build_scan(logic [BUTTON_COUNT-1:0] pressed);
    logic [SCAN_W-1:0] w;
    logic [1:0]        code;
    w = SCAN_W'($urandom_range(0, 65535));
    for (int k = 0; k < ENCODER_COUNT; k++) begin
      code = GRAY_SEQ[2*gray_pos[k] +: 2];
      w[scan_model.enc_map[8*k +: 4]]   = ~code[0];
      w[scan_model.enc_map[8*k+4 +: 4]] = ~code[1];
    end
    for (int b = 0; b < BUTTON_COUNT; b++)
      w[scan_model.btn_map[4*b +: 4]] = ~pressed[b];
    return w;
  endfunction

  task automatic move_all(input int dir);
    for (int k = 0; k < ENCODER_COUNT; k++) gray_pos[k] = (gray_pos[k] + dir) & 3;
  endtask

  task automatic random_scans(input int count);
    int pick;
    int j;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        for (int k = 0; k < ENCODER_COUNT; k++) begin
          if ($urandom_range(0, 7) == 0) spin_dir[k] = -spin_dir[k];
          if ($urandom_range(0, 3) != 0) gray_pos[k] = (gray_pos[k] + spin_dir[k]) & 3;
        end
        send_scan(build_scan(BUTTON_COUNT'($urandom_range(0, 127))));
      end else if (pick < 9) begin
        send_scan(SCAN_W'($urandom_range(0, 65535)));
      end else begin
        // skipped phase
        j = $urandom_range(0, ENCODER_COUNT - 1);
        gray_pos[j] = (gray_pos[j] + 2) & 3;
        send_scan(build_scan(BUTTON_COUNT'($urandom_range(0, 127))));
      end
    end
  endtask

  initial begin
    scan_model = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    for (int k = 0; k < ENCODER_COUNT; k++) begin
      gray_pos[k] = 0;
      spin_dir[k] = 1;
    end
    rst <= 1'b1;
    scan_valid <= 1'b0;
    scan_word <= '0;
    cfg_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_scan(16'hFFFF);
    send_scan(16'h0000);
    send_scan(16'hFFFF);
    send_scan(16'hAAAA);
    send_scan(16'h5555);
    send_scan(16'hFFFF);
    // full turns up with all buttons toggling, then back down into the lockout
    for (int i = 0; i < 8; i++) begin
      move_all(1);
      send_scan(build_scan((i % 2 == 0) ? 7'h7F : 7'h00));
    end
    for (int i = 0; i < 8; i++) begin
      move_all(-1);
      send_scan(build_scan((i % 2 == 0) ? 7'h7F : 7'h00));
    end
    random_scans(55);
    settle();

    apply_settings(32'h76543210, 32'h0EDCBA98, 8'd0, 4'd15, 4'd15);
    hold_req = 1'b1;
    random_scans(80);
    settle();

    apply_settings(32'hFEDCBA98, 32'h06543210, 8'd255, 4'd0, 4'd1);
    random_scans(80);
    settle();

    // every encoder on the same two pins, every button on bit 0
    apply_settings(32'h10101010, 32'h00000000, 8'd1, 4'd1, 4'd0);
    random_scans(70);
    settle();

    apply_settings($urandom, $urandom_range(0, 28'hFFFFFFF),
                   TICKS_W'($urandom_range(2, 20)),
                   SPEED_W'($urandom_range(0, 15)),
                   SPEED_W'($urandom_range(1, 15)));
    random_scans(70);
    settle();

    quiet = 1'b1;
    apply_settings(32'h1032AB89, 32'h0657FEDC, 8'd8, 4'd4, 4'd12);
    random_scans(90);
    settle();

    if (scan_model.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
